FILE: rtl/hfs_pkg.sv
// Shared types and constants for the hyperbolic force shaping block.
// Holds the beat structs that pass between cells and the fixed-point constants.
// No dependencies.
package hfs_pkg;

    // Fixed-point constants (Q30 unless stated)
    localparam logic [31:0] ACOSH4_Q30   = 32'd2215598682;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam int          LN2_SHIFT    = 40;
    localparam logic [10:0] LN2_RECIP    = 11'((64'd1 << LN2_SHIFT) / 64'd744261118);
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [33:0] U_SAT        = 34'h3_0000_0000;
    localparam logic [30:0] DIV_REM_INIT = 31'h2000_0000;
    localparam logic [48:0] C_BIAS       = 49'h0_8000_0000;
    localparam logic [48:0] ROUND_HALF   = 49'd8192;

    // Cell counts and total pipeline depth of one axis
    localparam int D1_CELLS     = 34;
    localparam int D2_CELLS     = 31;
    localparam int TAYLOR_TERMS = 13;
    localparam int PIPE_DEPTH   = 1 + D1_CELLS + 2 + 2 * TAYLOR_TERMS + 1 + D2_CELLS + 2;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ROBOT_X  = 3'd0;
    localparam logic [2:0] REG_ROBOT_Y  = 3'd1;
    localparam logic [2:0] REG_ROBOT_Z  = 3'd2;
    localparam logic [2:0] REG_DEVICE_X = 3'd3;
    localparam logic [2:0] REG_DEVICE_Y = 3'd4;
    localparam logic [2:0] REG_DEVICE_Z = 3'd5;

    localparam logic [30:0] ROBOT_LIMIT_RST  = 31'd6553600;
    localparam logic [30:0] DEVICE_LIMIT_RST = 31'd196608;

    // Reciprocals for exact floor(x / i), x < 2^31: q = (x * RECIP) >> SHIFT
    localparam logic [32:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
        33'((64'd1 << 31) / 64'd1),
        33'((64'd1 << 32) / 64'd2),
        33'(((64'd1 << 33) + 64'd2) / 64'd3),
        33'((64'd1 << 33) / 64'd4),
        33'(((64'd1 << 34) + 64'd4) / 64'd5),
        33'(((64'd1 << 34) + 64'd5) / 64'd6),
        33'(((64'd1 << 34) + 64'd6) / 64'd7),
        33'((64'd1 << 34) / 64'd8),
        33'(((64'd1 << 35) + 64'd8) / 64'd9),
        33'(((64'd1 << 35) + 64'd9) / 64'd10),
        33'(((64'd1 << 35) + 64'd10) / 64'd11),
        33'(((64'd1 << 35) + 64'd11) / 64'd12),
        33'(((64'd1 << 35) + 64'd12) / 64'd13)
    };
    localparam logic [5:0] TAYLOR_SHIFT [TAYLOR_TERMS] = '{
        6'd31, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34,
        6'd34, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35
    };

    // Per-item flags that ride along every stage
    typedef struct packed {
        logic       neg;
        logic       zero;
        logic       sat;
        logic [4:0] k;
    } side_t;

    // One beat of a restoring divider cell
    typedef struct packed {
        side_t       side;
        logic [30:0] dvsr;
        logic [30:0] rem;
        logic [33:0] word;
    } div_beat_t;

    // One beat of an exponential series cell
    typedef struct packed {
        side_t       side;
        logic [29:0] r;
        logic [30:0] term;
        logic [31:0] sum;
    } tay_beat_t;

endpackage

FILE: rtl/hyperbolic_force_shaping.sv
// Top level of the hyperbolic force shaping block: configuration registers,
// beat tracking, output register and three axis pipelines. Depends on hfs_pkg, hfs_axis.
//
// Usage:
//   Input channel in_valid/in_ready carries one three-axis force sample per beat
//   (force_x/y/z, signed Q16.16). Output channel out_valid/out_ready carries the
//   shaped, clamped forces shaped_x/y/z (signed Q16.16), one result per sample.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0..2 robot
//   limits x/y/z, 3..5 device limits x/y/z); other indexes are ignored. Write
//   only while no sample is in flight.
//   Path: 97 pipeline stages, then the output register that drives out_valid.
//   Throughput: one sample per cycle while in_ready is high; each axis is a row
//   of cells (34 divider cells, 13 two-stage series cells, 31 divider cells)
//   that all advance together.
//   Reset: drops every in-flight beat, clears out_valid and loads the
//   default limits (robot 100.0, device 3.0).
//   Stall: a result waiting in the output register does not block the row;
//   the row freezes, and in_ready drops, only when its last stage also holds a
//   result.
module hyperbolic_force_shaping (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] shaped_x,
    output logic signed [31:0] shaped_y,
    output logic signed [31:0] shaped_z,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);
    import hfs_pkg::*;

    // Configuration registers
    logic [30:0] robot_limit_reg  [3];
    logic [30:0] device_limit_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                robot_limit_reg[i]  <= ROBOT_LIMIT_RST;
                device_limit_reg[i] <= DEVICE_LIMIT_RST;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROBOT_X:  robot_limit_reg[0]  <= cfg_data;
                REG_ROBOT_Y:  robot_limit_reg[1]  <= cfg_data;
                REG_ROBOT_Z:  robot_limit_reg[2]  <= cfg_data;
                REG_DEVICE_X: device_limit_reg[0] <= cfg_data;
                REG_DEVICE_Y: device_limit_reg[1] <= cfg_data;
                REG_DEVICE_Z: device_limit_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Beat tracking along the row
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  last_vld;
    logic                  pipe_en;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    assign last_vld = vld_reg[PIPE_DEPTH-1];
    assign pipe_en  = !(last_vld && out_valid_reg && !out_ready);
    assign in_ready = pipe_en;

    always_comb
    begin
        vld_next = pipe_en ? {vld_reg[PIPE_DEPTH-2:0], in_valid} : vld_reg;
    end

    // Load the output register when the row hands over a beat, clear it once out_ready takes it
    always_comb
    begin
        if (pipe_en && last_vld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Axis rows
    logic signed [31:0] axis_out [3];
    logic signed [31:0] force_arr [3];

    assign force_arr[0] = force_x;
    assign force_arr[1] = force_y;
    assign force_arr[2] = force_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        hfs_axis u_axis (
            .clk          (clk),
            .en           (pipe_en),
            .force_in     (force_arr[a]),
            .robot_limit  (robot_limit_reg[a]),
            .device_limit (device_limit_reg[a]),
            .shaped       (axis_out[a])
        );
    end

    // Output payload register
    logic signed [31:0] shaped_reg [3];

    always_ff @(posedge clk)
    begin
        if (pipe_en && last_vld)
        begin
            for (int i = 0; i < 3; i++)
            begin
                shaped_reg[i] <= axis_out[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign shaped_x  = shaped_reg[0];
    assign shaped_y  = shaped_reg[1];
    assign shaped_z  = shaped_reg[2];

`ifndef SYNTHESIS
    a_accept_enters_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat did not enter the row");

    a_row_hands_over: assert property (@(posedge clk) disable iff (!rst_n)
        last_vld && (!out_valid_reg || out_ready) |=> out_valid_reg)
        else $error("finished beat not moved to the output register");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("row moved while frozen");
`endif

endmodule

FILE: rtl/hfs_div_cell.sv
// One restoring division step: brings in one dividend bit, emits one quotient bit.
// Depends on hfs_pkg for div_beat_t.
module hfs_div_cell (
    input  logic              clk,
    input  logic              en,
    input  hfs_pkg::div_beat_t din,
    output hfs_pkg::div_beat_t dout
);
    import hfs_pkg::*;

    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;
    div_beat_t   beat_next;
    div_beat_t   beat_reg;

    // Compare shifted remainder with divisor, subtract when it fits
    always_comb
    begin
        trial          = {din.rem, din.word[33]};
        diff           = trial - {1'b0, din.dvsr};
        ge             = (trial >= {1'b0, din.dvsr});
        beat_next      = din;
        beat_next.rem  = ge ? diff[30:0] : trial[30:0];
        beat_next.word = {din.word[32:0], ge};
    end

    // Hold the beat for the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dout = beat_reg;

endmodule

FILE: rtl/hfs_taylor_cell.sv
// One term of the exponential series: t_i = floor(floor(t_{i-1} * r / 2^30) / i).
// Two stages: product, then division by the term index. Depends on hfs_pkg.
module hfs_taylor_cell (
    input  logic              clk,
    input  logic              en,
    input  logic [3:0]        idx,
    input  hfs_pkg::tay_beat_t din,
    output hfs_pkg::tay_beat_t dout
);
    import hfs_pkg::*;

    logic [60:0] prod1;
    logic [63:0] prod2;
    logic [63:0] quot;
    tay_beat_t   s1_next;
    tay_beat_t   s1_reg;
    tay_beat_t   s2_next;
    tay_beat_t   s2_reg;

    // Accumulate the incoming term, scale it by r
    always_comb
    begin
        prod1        = 61'(din.term) * 61'(din.r);
        s1_next      = din;
        s1_next.sum  = din.sum + {1'b0, din.term};
        s1_next.term = prod1[60:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    // Divide by the term index through its reciprocal
    always_comb
    begin
        prod2        = 64'(s1_reg.term) * 64'(TAYLOR_RECIP[idx]);
        quot         = prod2 >> TAYLOR_SHIFT[idx];
        s2_next      = s1_reg;
        s2_next.term = quot[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dout = s2_reg;

endmodule

FILE: rtl/hfs_axis.sv
// Shaping pipeline of one axis: scale, divide by robot limit, range-reduce, series,
// reciprocal, cosh assembly and clamp. Depends on hfs_pkg, hfs_div_cell, hfs_taylor_cell.
module hfs_axis (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] force_in,
    input  logic [30:0]        robot_limit,
    input  logic [30:0]        device_limit,
    output logic signed [31:0] shaped
);
    import hfs_pkg::*;

    // Stage A: magnitude and scale by acosh(4)
    logic [31:0] mag_a;
    logic [63:0] prod_a;
    side_t       side_a;
    logic [62:0] a_prod_reg;
    side_t       a_side_reg;

    always_comb
    begin
        mag_a       = force_in[31] ? (32'd0 - force_in) : force_in;
        prod_a      = 64'(mag_a) * 64'(ACOSH4_Q30);
        side_a.neg  = force_in[31];
        side_a.zero = (mag_a == 32'd0);
        side_a.sat  = 1'b0;
        side_a.k    = 5'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= prod_a[62:0];
            a_side_reg <= side_a;
        end
    end

    // First division: u = p / robot_limit, saturate when the quotient passes 34 bits
    div_beat_t d1 [D1_CELLS + 1];
    div_beat_t d1_seed;
    logic [30:0] p_hi;
    logic        ovf;

    always_comb
    begin
        p_hi              = {2'b00, a_prod_reg[62:34]};
        ovf               = (p_hi >= robot_limit);
        d1_seed.side      = a_side_reg;
        d1_seed.side.sat  = ovf;
        d1_seed.dvsr      = robot_limit;
        d1_seed.rem       = ovf ? 31'd0 : p_hi;
        d1_seed.word      = a_prod_reg[33:0];
    end

    assign d1[0] = d1_seed;

    for (genvar i = 0; i < D1_CELLS; i++)
    begin : g_d1
        hfs_div_cell u_cell (
            .clk  (clk),
            .en   (en),
            .din  (d1[i]),
            .dout (d1[i + 1])
        );
    end

    // Stage K1: estimate k = u / ln2 by reciprocal
    logic [44:0] prod_k;
    side_t       side_k1;
    logic [33:0] k1_u_reg;
    logic [4:0]  k1_est_reg;
    side_t       k1_side_reg;

    always_comb
    begin
        prod_k      = 45'(d1[D1_CELLS].word) * 45'(LN2_RECIP);
        side_k1     = d1[D1_CELLS].side;
        side_k1.sat = d1[D1_CELLS].side.sat | (d1[D1_CELLS].word >= U_SAT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_u_reg    <= d1[D1_CELLS].word;
            k1_est_reg  <= prod_k[LN2_SHIFT +: 5];
            k1_side_reg <= side_k1;
        end
    end

    // Stage K2: correct the estimate, form remainder r in [0, ln2)
    logic [34:0] r0;
    logic        r_ge;
    logic [34:0] r1;
    tay_beat_t   k2_next;
    tay_beat_t   k2_reg;

    always_comb
    begin
        r0             = 35'(k1_u_reg) - 35'(k1_est_reg) * 35'(LN2_Q30);
        r_ge           = (r0 >= 35'(LN2_Q30));
        r1             = r_ge ? (r0 - 35'(LN2_Q30)) : r0;
        k2_next.side   = k1_side_reg;
        k2_next.side.k = k1_est_reg + 5'(r_ge);
        k2_next.r      = r1[29:0];
        k2_next.term   = ONE_Q30;
        k2_next.sum    = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_reg <= k2_next;
        end
    end

    // Exponential series cells
    tay_beat_t t [TAYLOR_TERMS + 1];
    assign t[0] = k2_reg;

    for (genvar i = 0; i < TAYLOR_TERMS; i++)
    begin : g_tay
        hfs_taylor_cell u_cell (
            .clk  (clk),
            .en   (en),
            .idx  (4'(i)),
            .din  (t[i]),
            .dout (t[i + 1])
        );
    end

    // Stage E: close the sum, seed the reciprocal division 2^60 / e
    logic [31:0] e_sum;
    div_beat_t   e_next;
    div_beat_t   e_reg;

    always_comb
    begin
        e_sum       = t[TAYLOR_TERMS].sum + {1'b0, t[TAYLOR_TERMS].term};
        e_next.side = t[TAYLOR_TERMS].side;
        e_next.dvsr = e_sum[30:0];
        e_next.rem  = DIV_REM_INIT;
        e_next.word = 34'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
        end
    end

    div_beat_t d2 [D2_CELLS + 1];
    assign d2[0] = e_reg;

    for (genvar i = 0; i < D2_CELLS; i++)
    begin : g_d2
        hfs_div_cell u_cell (
            .clk  (clk),
            .en   (en),
            .din  (d2[i]),
            .dout (d2[i + 1])
        );
    end

    // Stage F1: c = (e << k + (2^60 / e) >> k - 2^31) / 2
    logic [47:0] ep;
    logic [30:0] en_q;
    logic [48:0] s_sum;
    logic [48:0] s_diff;
    logic [47:0] c_next;
    logic [47:0] f1_c_reg;
    side_t       f1_side_reg;

    always_comb
    begin
        ep     = 48'(d2[D2_CELLS].dvsr) << d2[D2_CELLS].side.k;
        en_q   = d2[D2_CELLS].word[30:0] >> d2[D2_CELLS].side.k;
        s_sum  = 49'(ep) + 49'(en_q);
        s_diff = s_sum - C_BIAS;
        c_next = (s_sum >= C_BIAS) ? s_diff[48:1] : 48'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_c_reg    <= c_next;
            f1_side_reg <= d2[D2_CELLS].side;
        end
    end

    // Stage F2: round to Q16, clamp, pick special cases, apply sign
    logic [48:0] m_round;
    logic [34:0] m_val;
    logic [30:0] mag_f;
    logic [30:0] sel_f;
    logic [31:0] sel_w;
    logic signed [31:0] shaped_next;
    logic signed [31:0] shaped_reg;

    always_comb
    begin
        m_round = 49'(f1_c_reg) + ROUND_HALF;
        m_val   = m_round[48:14];
        mag_f   = (m_val > 35'(device_limit)) ? device_limit : m_val[30:0];
        if (f1_side_reg.zero)
        begin
            sel_f = 31'd0;
        end
        else if (f1_side_reg.sat)
        begin
            sel_f = device_limit;
        end
        else
        begin
            sel_f = mag_f;
        end
        sel_w       = {1'b0, sel_f};
        shaped_next = f1_side_reg.neg ? (32'd0 - sel_w) : sel_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shaped_reg <= shaped_next;
        end
    end

    assign shaped = shaped_reg;

endmodule
